/* rtl/core/hffb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hffb_pkg: shared types and constants for the Fock build block
// Widths, operation codes, sequencer states and the control struct.
// ----------------------------------------------------------------------------
package hffb_pkg;

    localparam int MaxBasis = 8;
    localparam int IdxW     = 3;                    // bits of one index
    localparam int SqW      = 2 * IdxW;             // address of a square store
    localparam int QuW      = 4 * IdxW;             // address of the integral store
    localparam int DataW    = 32;
    localparam int AccW     = 64;
    localparam int CntW     = IdxW + 1;             // holds 0..MaxBasis
    localparam logic [16:0] WeightOne = 17'd65536;

    typedef enum logic [2:0] {
        OP_LOAD_UP   = 3'd0,
        OP_LOAD_DOWN = 3'd1,
        OP_LOAD_CORE = 3'd2,
        OP_LOAD_INT  = 3'd3,
        OP_RUN       = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        CFG_BASIS    = 2'd0,
        CFG_OCC_UP   = 2'd1,
        CFG_OCC_DOWN = 2'd2,
        CFG_WEIGHT   = 2'd3
    } t_cfg_idx;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DENS_RD,     // issue coefficient reads for one density term
        ST_DENS_ACC,    // accumulate product of one term
        ST_BLEND_RD,    // read old densities
        ST_BLEND_MUL,   // blend multiply
        ST_BLEND_WR,    // write blended densities
        ST_FOCK_RD,     // issue density/integral reads
        ST_FOCK_ACC,    // accumulate one contraction term
        ST_CORE_RD,     // read core entry
        ST_EMIT         // register result for the output channel
    } t_state;

    // memory access requests from the sequencer to the store unit
    typedef struct packed {
        logic           coef_rd;
        logic [SqW-1:0] coef_a;     // [m][i]
        logic [SqW-1:0] coef_b;     // [v][i]
        logic           dens_rd;
        logic [SqW-1:0] dens_a;
        logic           dens_wr;
        logic [SqW-1:0] dens_wa;
        logic           int_rd;
        logic [QuW-1:0] int_ca;     // coulomb address
        logic [QuW-1:0] int_xa;     // exchange address
        logic           core_rd;
        logic [SqW-1:0] core_a;
    } t_mem_req;

    function automatic logic signed [AccW-1:0] round16(input logic signed [AccW-1:0] x);
        logic signed [AccW-1:0] t;
        t = x + 64'sd32768;
        return t >>> 16;
    endfunction

    function automatic logic signed [DataW-1:0] sat32(input logic signed [AccW-1:0] x);
        if (x > 64'sh0000_0000_7fff_ffff)
            return 32'sh7fff_ffff;
        else if (x < -64'sh0000_0000_8000_0000)
            return 32'sh8000_0000;
        else
            return x[DataW-1:0];
    endfunction

endpackage

/* rtl/core/hffb_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hffb_in_if / hffb_out_if: valid/ready channels of the Fock build block
// Input channel carries load and run transactions, output channel the results.
// ----------------------------------------------------------------------------
interface hffb_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [2:0]  row_index;
    logic [2:0]  col_index;
    logic [2:0]  third_index;
    logic [2:0]  fourth_index;
    logic signed [31:0] value;

    modport source (output valid, operation, row_index, col_index, third_index,
                    fourth_index, value, input ready);
    modport sink   (input valid, operation, row_index, col_index, third_index,
                    fourth_index, value, output ready);
endinterface

interface hffb_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  out_row;
    logic [2:0]  out_col;
    logic signed [31:0] fock_up;
    logic signed [31:0] fock_down;
    logic        last;

    modport source (output valid, out_row, out_col, fock_up, fock_down, last,
                    input ready);
    modport sink   (input valid, out_row, out_col, fock_up, fock_down, last,
                    output ready);
endinterface

/* rtl/core/hartree_fock_fock_build.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hartree_fock_fock_build: unrestricted Fock matrix build, Q16.16
// Each load transaction writes one store entry. A run transaction walks
// the n basis functions with the multiply-accumulate datapath, which reads
// the integral and density memories one term at a time, each term taking a
// read state and an accumulate state; results stream out in row-major order
// with the final entry flagged. No transaction is taken while a run is in
// progress.
// ----------------------------------------------------------------------------
module hartree_fock_fock_build
    import hffb_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [16:0]    i_cfg_data,
    hffb_in_if.sink        in_if,
    hffb_out_if.source     out_if
);

    logic [3:0]  r_basis, r_occ_up, r_occ_dn;
    logic [16:0] r_weight;
    logic busy, accept, ld_en, start;
    logic [CntW-1:0] n_eff, ou_eff, od_eff;
    logic [16:0] w_eff;
    t_op op;
    t_mem_req req;
    logic signed [DataW-1:0] pu_wd, pd_wd, cu_a, cu_b, cd_a, cd_b, pu, pd, ic, ix, core;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_basis  <= 4'd8;
            r_occ_up <= '0;
            r_occ_dn <= '0;
            r_weight <= WeightOne;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_BASIS:    r_basis  <= i_cfg_data[3:0];
                CFG_OCC_UP:   r_occ_up <= i_cfg_data[3:0];
                CFG_OCC_DOWN: r_occ_dn <= i_cfg_data[3:0];
                CFG_WEIGHT:   r_weight <= i_cfg_data;
            endcase
        end
    end

    // clamp run parameters
    assign n_eff  = (r_basis > CntW'(MaxBasis)) ? CntW'(MaxBasis) : r_basis;
    assign ou_eff = (r_occ_up > n_eff) ? n_eff : r_occ_up;
    assign od_eff = (r_occ_dn > n_eff) ? n_eff : r_occ_dn;
    assign w_eff  = (r_weight > WeightOne) ? WeightOne : r_weight;

    assign op     = t_op'(in_if.operation);
    assign in_if.ready = !busy;
    assign accept = in_if.valid && in_if.ready;
    assign ld_en  = accept && (op == OP_LOAD_UP || op == OP_LOAD_DOWN ||
                               op == OP_LOAD_CORE || op == OP_LOAD_INT);
    assign start  = accept && op == OP_RUN && n_eff != '0;

    hffb_store u_store (
        .i_clk, .i_rst_n,
        .i_ld_en (ld_en),
        .i_ld_op (op),
        .i_ld_sq ({in_if.row_index, in_if.col_index}),
        .i_ld_qu ({in_if.row_index, in_if.col_index, in_if.third_index,
                   in_if.fourth_index}),
        .i_ld_val(in_if.value),
        .i_req   (req),
        .i_dens_up_wd(pu_wd), .i_dens_dn_wd(pd_wd),
        .o_cu_a(cu_a), .o_cu_b(cu_b), .o_cd_a(cd_a), .o_cd_b(cd_b),
        .o_pu(pu), .o_pd(pd), .o_ic(ic), .o_ix(ix), .o_core(core)
    );

    hffb_seq u_seq (
        .i_clk, .i_rst_n,
        .i_start(start), .i_n(n_eff), .i_ou(ou_eff), .i_od(od_eff), .i_w(w_eff),
        .o_busy(busy), .o_req(req),
        .o_dens_up_wd(pu_wd), .o_dens_dn_wd(pd_wd),
        .i_cu_a(cu_a), .i_cu_b(cu_b), .i_cd_a(cd_a), .i_cd_b(cd_b),
        .i_pu(pu), .i_pd(pd), .i_ic(ic), .i_ix(ix), .i_core(core),
        .out_if(out_if)
    );

endmodule

/* rtl/core/hffb_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hffb_store: coefficient, core, integral and density memories
// Synchronous memories with registered read data. Densities carry valid
// bits so that reset clears them at once.
// ----------------------------------------------------------------------------
module hffb_store
    import hffb_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // loads
    input  logic                     i_ld_en,
    input  t_op                      i_ld_op,
    input  logic [SqW-1:0]           i_ld_sq,
    input  logic [QuW-1:0]           i_ld_qu,
    input  logic signed [DataW-1:0]  i_ld_val,
    // sequencer access
    input  t_mem_req                 i_req,
    input  logic signed [DataW-1:0]  i_dens_up_wd,
    input  logic signed [DataW-1:0]  i_dens_dn_wd,
    output logic signed [DataW-1:0]  o_cu_a,
    output logic signed [DataW-1:0]  o_cu_b,
    output logic signed [DataW-1:0]  o_cd_a,
    output logic signed [DataW-1:0]  o_cd_b,
    output logic signed [DataW-1:0]  o_pu,
    output logic signed [DataW-1:0]  o_pd,
    output logic signed [DataW-1:0]  o_ic,
    output logic signed [DataW-1:0]  o_ix,
    output logic signed [DataW-1:0]  o_core
);

    logic signed [DataW-1:0] m_cu   [MaxBasis*MaxBasis];
    logic signed [DataW-1:0] m_cd   [MaxBasis*MaxBasis];
    logic signed [DataW-1:0] m_core [MaxBasis*MaxBasis];
    logic signed [DataW-1:0] m_int  [MaxBasis**4];
    logic signed [DataW-1:0] m_pu   [MaxBasis*MaxBasis];
    logic signed [DataW-1:0] m_pd   [MaxBasis*MaxBasis];
    logic [MaxBasis*MaxBasis-1:0] r_pvalid;
    logic r_pv_q;
    logic signed [DataW-1:0] r_pu_raw, r_pd_raw;

    // coefficient stores: one write port (load), two read ports
    always_ff @(posedge i_clk) begin
        if (i_ld_en && i_ld_op == OP_LOAD_UP)
            m_cu[i_ld_sq] <= i_ld_val;
        if (i_ld_en && i_ld_op == OP_LOAD_DOWN)
            m_cd[i_ld_sq] <= i_ld_val;
        if (i_req.coef_rd) begin
            o_cu_a <= m_cu[i_req.coef_a];
            o_cu_b <= m_cu[i_req.coef_b];
            o_cd_a <= m_cd[i_req.coef_a];
            o_cd_b <= m_cd[i_req.coef_b];
        end
    end

    // core store
    always_ff @(posedge i_clk) begin
        if (i_ld_en && i_ld_op == OP_LOAD_CORE)
            m_core[i_ld_sq] <= i_ld_val;
        if (i_req.core_rd)
            o_core <= m_core[i_req.core_a];
    end

    // integral store: coulomb and exchange read ports
    always_ff @(posedge i_clk) begin
        if (i_ld_en && i_ld_op == OP_LOAD_INT)
            m_int[i_ld_qu] <= i_ld_val;
        if (i_req.int_rd) begin
            o_ic <= m_int[i_req.int_ca];
            o_ix <= m_int[i_req.int_xa];
        end
    end

    // density stores
    always_ff @(posedge i_clk) begin
        if (i_req.dens_wr) begin
            m_pu[i_req.dens_wa] <= i_dens_up_wd;
            m_pd[i_req.dens_wa] <= i_dens_dn_wd;
        end
        if (i_req.dens_rd) begin
            r_pu_raw <= m_pu[i_req.dens_a];
            r_pd_raw <= m_pd[i_req.dens_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= '0;
            r_pv_q   <= 1'b0;
        end else begin
            if (i_req.dens_wr)
                r_pvalid[i_req.dens_wa] <= 1'b1;
            if (i_req.dens_rd)
                r_pv_q <= r_pvalid[i_req.dens_a];
        end
    end

    assign o_pu = r_pv_q ? r_pu_raw : '0;
    assign o_pd = r_pv_q ? r_pd_raw : '0;

endmodule

/* rtl/core/hffb_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hffb_seq: run sequencer and multiply-accumulate datapath
// Walks the density pass and then the Fock contraction, each term taking
// a memory read state followed by a multiply-accumulate state.
// ----------------------------------------------------------------------------
module hffb_seq
    import hffb_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [CntW-1:0]          i_n,
    input  logic [CntW-1:0]          i_ou,
    input  logic [CntW-1:0]          i_od,
    input  logic [16:0]              i_w,
    output logic                     o_busy,
    output t_mem_req                 o_req,
    output logic signed [DataW-1:0]  o_dens_up_wd,
    output logic signed [DataW-1:0]  o_dens_dn_wd,
    input  logic signed [DataW-1:0]  i_cu_a,
    input  logic signed [DataW-1:0]  i_cu_b,
    input  logic signed [DataW-1:0]  i_cd_a,
    input  logic signed [DataW-1:0]  i_cd_b,
    input  logic signed [DataW-1:0]  i_pu,
    input  logic signed [DataW-1:0]  i_pd,
    input  logic signed [DataW-1:0]  i_ic,
    input  logic signed [DataW-1:0]  i_ix,
    input  logic signed [DataW-1:0]  i_core,
    hffb_out_if.source               out_if
);

    t_state r_state, n_state;
    logic [IdxW-1:0] r_m, n_m, r_v, n_v, r_l, n_l, r_s, n_s;
    logic [CntW-1:0] r_i, n_i;
    logic signed [AccW-1:0] r_acc_a, n_acc_a, r_acc_b, n_acc_b, r_acc_c, n_acc_c;
    logic signed [AccW-1:0] r_pa, n_pa, r_pb, n_pb;
    logic signed [AccW-1:0] r_pa2, n_pa2, r_pb2, n_pb2;
    logic r_ovalid, n_ovalid;
    logic [IdxW-1:0] r_orow, n_orow, r_ocol, n_ocol;
    logic signed [DataW-1:0] r_fu, n_fu, r_fd, n_fd;
    logic r_olast, n_olast;
    logic [CntW-1:0] r_n;
    logic [CntW-1:0] r_ou, r_od;
    logic [16:0] r_w;
    logic signed [DataW-1:0] fresh_u, fresh_d, ptot;
    logic last_v, last_s, last_l;
    logic signed [AccW-1:0] core_x;

    assign last_v = ({1'b0, r_v} == r_n - 1'b1);
    assign last_l = ({1'b0, r_l} == r_n - 1'b1);
    assign last_s = ({1'b0, r_s} == r_n - 1'b1);
    assign fresh_u = sat32(r_acc_a);
    assign fresh_d = sat32(r_acc_b);
    assign ptot = sat32(AccW'(i_pu) + AccW'(i_pd));
    assign core_x = AccW'(i_core);

    // run parameters captured at start
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n  <= i_n;
            r_ou <= i_ou;
            r_od <= i_od;
            r_w  <= i_w;
        end
    end

    // state and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_m <= n_m; r_v <= n_v; r_l <= n_l; r_s <= n_s; r_i <= n_i;
        r_acc_a <= n_acc_a; r_acc_b <= n_acc_b; r_acc_c <= n_acc_c;
        r_pa <= n_pa; r_pb <= n_pb;
        r_pa2 <= n_pa2; r_pb2 <= n_pb2;
        r_orow <= n_orow; r_ocol <= n_ocol;
        r_fu <= n_fu; r_fd <= n_fd; r_olast <= n_olast;
    end

    // next state, memory requests and arithmetic
    always_comb begin
        n_state = r_state;
        n_m = r_m; n_v = r_v; n_l = r_l; n_s = r_s; n_i = r_i;
        n_acc_a = r_acc_a; n_acc_b = r_acc_b; n_acc_c = r_acc_c;
        n_pa = r_pa; n_pb = r_pb; n_pa2 = r_pa2; n_pb2 = r_pb2;
        n_ovalid = r_ovalid;
        n_orow = r_orow; n_ocol = r_ocol;
        n_fu = r_fu; n_fd = r_fd; n_olast = r_olast;
        o_req = '0;
        o_dens_up_wd = sat32(round16(r_pa + r_pa2));
        o_dens_dn_wd = sat32(round16(r_pb + r_pb2));
        o_req.coef_a = {r_m, r_i[IdxW-1:0]};
        o_req.coef_b = {r_v, r_i[IdxW-1:0]};
        o_req.dens_a = {r_l, r_s};
        o_req.dens_wa = {r_m, r_v};
        o_req.int_ca = {r_m, r_v, r_l, r_s};
        o_req.int_xa = {r_m, r_l, r_s, r_v};
        o_req.core_a = {r_m, r_v};
        if (r_ovalid && out_if.ready)
            n_ovalid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_m = '0; n_v = '0; n_i = '0;
                    n_acc_a = '0; n_acc_b = '0;
                    n_state = ST_DENS_RD;
                end
            end
            ST_DENS_RD: begin
                // skip terms past both occupations
                if (r_i >= r_ou && r_i >= r_od) begin
                    n_state = ST_BLEND_RD;
                end else begin
                    o_req.coef_rd = 1'b1;
                    n_state = ST_DENS_ACC;
                end
            end
            ST_DENS_ACC: begin
                if (r_i < r_ou)
                    n_acc_a = r_acc_a + round16(AccW'(i_cu_a) * AccW'(i_cu_b));
                if (r_i < r_od)
                    n_acc_b = r_acc_b + round16(AccW'(i_cd_a) * AccW'(i_cd_b));
                n_i = r_i + 1'b1;
                n_state = ST_DENS_RD;
            end
            ST_BLEND_RD: begin
                o_req.dens_rd = 1'b1;
                o_req.dens_a = {r_m, r_v};
                n_state = ST_BLEND_MUL;
            end
            ST_BLEND_MUL: begin
                n_pa  = AccW'(r_w) * AccW'(fresh_u);
                n_pb  = AccW'(r_w) * AccW'(fresh_d);
                n_pa2 = AccW'(WeightOne - r_w) * AccW'(i_pu);
                n_pb2 = AccW'(WeightOne - r_w) * AccW'(i_pd);
                n_state = ST_BLEND_WR;
            end
            ST_BLEND_WR: begin
                o_req.dens_wr = 1'b1;
                n_i = '0; n_acc_a = '0; n_acc_b = '0;
                n_state = ST_DENS_RD;
                if (last_v) begin
                    n_v = '0;
                    if ({1'b0, r_m} == r_n - 1'b1) begin
                        n_m = '0; n_l = '0; n_s = '0;
                        n_acc_c = '0;
                        n_state = ST_FOCK_RD;
                    end else begin
                        n_m = r_m + 1'b1;
                    end
                end else begin
                    n_v = r_v + 1'b1;
                end
            end
            ST_FOCK_RD: begin
                o_req.dens_rd = 1'b1;
                o_req.int_rd  = 1'b1;
                n_state = ST_FOCK_ACC;
            end
            ST_FOCK_ACC: begin
                // contraction terms, sums restart on the first term of an entry
                if (r_l == '0 && r_s == '0) begin
                    n_acc_c = round16(AccW'(ptot) * AccW'(i_ic));
                    n_acc_a = round16(AccW'(i_pu) * AccW'(i_ix));
                    n_acc_b = round16(AccW'(i_pd) * AccW'(i_ix));
                end else begin
                    n_acc_c = r_acc_c + round16(AccW'(ptot) * AccW'(i_ic));
                    n_acc_a = r_acc_a + round16(AccW'(i_pu) * AccW'(i_ix));
                    n_acc_b = r_acc_b + round16(AccW'(i_pd) * AccW'(i_ix));
                end
                n_state = ST_FOCK_RD;
                if (last_s) begin
                    n_s = '0;
                    if (last_l) begin
                        n_l = '0;
                        n_state = ST_CORE_RD;
                    end else begin
                        n_l = r_l + 1'b1;
                    end
                end else begin
                    n_s = r_s + 1'b1;
                end
            end
            ST_CORE_RD: begin
                o_req.core_rd = 1'b1;
                if (!r_ovalid || out_if.ready)
                    n_state = ST_EMIT;
            end
            ST_EMIT: begin
                n_ovalid = 1'b1;
                n_orow = r_m; n_ocol = r_v;
                n_fu = sat32(core_x + r_acc_c - r_acc_a);
                n_fd = sat32(core_x + r_acc_c - r_acc_b);
                n_olast = last_v && ({1'b0, r_m} == r_n - 1'b1);
                n_state = ST_FOCK_RD;
                if (last_v) begin
                    n_v = '0;
                    if ({1'b0, r_m} == r_n - 1'b1)
                        n_state = ST_IDLE;
                    else
                        n_m = r_m + 1'b1;
                end else begin
                    n_v = r_v + 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE) || r_ovalid;
    assign out_if.valid     = r_ovalid;
    assign out_if.out_row   = r_orow;
    assign out_if.out_col   = r_ocol;
    assign out_if.fock_up   = r_fu;
    assign out_if.fock_down = r_fd;
    assign out_if.last      = r_olast;

    // a result is only overwritten after it has been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !out_if.ready) |=> $stable(r_fu) && $stable(r_fd))
        else $error("pending result changed");
    // density writes only happen during the density pass
    a_dens_wr_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req.dens_wr |-> r_state == ST_BLEND_WR)
        else $error("density write outside blend");
    // last flag leaves the run and returns idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && n_olast) |=> r_state == ST_IDLE)
        else $error("run did not end after last entry");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the unrestricted Fock build block
// Drives load, run and stray transactions with random gaps and stalls. A
// behavioural Q16.16 copy of the block predicts every Fock entry in order,
// and each output transaction is compared field by field with it.
// ----------------------------------------------------------------------------
module testbench;
    import hffb_pkg::*;

    localparam int CYCLE_LIMIT   = 20000;   // cycles with no transaction at all
    localparam int HOLD_CYCLES   = 400;     // long receiver stall
    localparam int SETTLE_CYCLES = 16;      // idle time before a register write
    localparam int DRAIN_CYCLES  = 64;
    localparam int PHASES        = 11;
    localparam int ITEM_TARGET   = 170;
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
    localparam int SQ = MaxBasis * MaxBasis;

    typedef struct {
        logic [2:0] row;
        logic [2:0] col;
        int         up;
        int         dn;
        logic       last;
    } fock_entry_t;

    typedef struct {
        bit          is_reg;
        t_cfg_idx    reg_idx;
        logic [16:0] reg_val;
        logic [2:0]  op;
        logic [2:0]  r, c, t, f;
        int          val;
        bit          typed;
        int          exp_fock;
    } stim_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [16:0] i_cfg_data;

    hffb_in_if  in_ch ();
    hffb_out_if out_ch ();

    hartree_fock_fock_build DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_if      (in_ch),
        .out_if     (out_ch)
    );

    // predictor state
    int          coef_up [SQ];
    int          coef_dn [SQ];
    int          core_m  [SQ];
    int          eri     [SQ*SQ];
    int          dens_up [SQ];
    int          dens_dn [SQ];
    bit          wr_up   [SQ];
    bit          wr_dn   [SQ];
    bit          wr_core [SQ];
    bit          wr_eri  [SQ*SQ];
    logic [3:0]  n_basis  = 4'd8;
    logic [3:0]  n_occ_up = 4'd0;
    logic [3:0]  n_occ_dn = 4'd0;
    logic [16:0] mix_w    = WeightOne;

    fock_entry_t fock_q[$];
    stim_row_t   dir_q[$];
    int          errs       = 0;
    int          items_sent = 0;
    int          stall_cnt  = 0;
    bit          quiet      = 0;
    bit          hold_req   = 0;

    // clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Q16.16 helpers
    // ------------------------------------------------------------------
    function automatic longint q16_round(longint x);
        return (x + 64'sd32768) >>> 16;
    endfunction

    function automatic int q16_clip(longint x);
        if (x > 64'sd2147483647)
            return 32'sh7fff_ffff;
        if (x < -64'sd2147483648)
            return 32'sh8000_0000;
        return int'(x);
    endfunction

    // density from the occupied columns of one spin
    function automatic int fresh_dens(bit down, int m, int v, int occ);
        longint acc;
        acc = 0;
        for (int i = 0; i < occ; i++) begin
            if (down)
                acc += q16_round(longint'(coef_dn[m*MaxBasis+i]) * coef_dn[v*MaxBasis+i]);
            else
                acc += q16_round(longint'(coef_up[m*MaxBasis+i]) * coef_up[v*MaxBasis+i]);
        end
        return q16_clip(acc);
    endfunction

    // ------------------------------------------------------------------
    // Predictor: one accepted input transaction
    // ------------------------------------------------------------------
    task automatic fock_predict(input logic [2:0] op, input logic [2:0] r, c, t, f,
                                input int val);
        int          n, ou, od, k, kk, pu, pd;
        longint      w, acc_j, acc_u, acc_d, pt;
        longint      ptot [SQ];
        fock_entry_t e;
        k = r * MaxBasis + c;
        case (op)
            OP_LOAD_UP: begin
                coef_up[k] = val;
                wr_up[k]   = 1;
            end
            OP_LOAD_DOWN: begin
                coef_dn[k] = val;
                wr_dn[k]   = 1;
            end
            OP_LOAD_CORE: begin
                core_m[k]  = val;
                wr_core[k] = 1;
            end
            OP_LOAD_INT: begin
                kk = ((r * MaxBasis + c) * MaxBasis + t) * MaxBasis + f;
                eri[kk]    = val;
                wr_eri[kk] = 1;
            end
            OP_RUN: begin
                n  = (n_basis > MaxBasis) ? MaxBasis : n_basis;
                ou = (n_occ_up < n) ? n_occ_up : n;
                od = (n_occ_dn < n) ? n_occ_dn : n;
                w  = (mix_w > WeightOne) ? 65536 : mix_w;
                // blended densities and total
                for (int m = 0; m < n; m++) begin
                    for (int v = 0; v < n; v++) begin
                        kk = m * MaxBasis + v;
                        pu = fresh_dens(0, m, v, ou);
                        pd = fresh_dens(1, m, v, od);
                        dens_up[kk] = q16_clip(q16_round(w * pu + (65536 - w) * dens_up[kk]));
                        dens_dn[kk] = q16_clip(q16_round(w * pd + (65536 - w) * dens_dn[kk]));
                        ptot[kk]    = q16_clip(longint'(dens_up[kk]) + dens_dn[kk]);
                    end
                end
                // Coulomb and exchange contractions
                for (int m = 0; m < n; m++) begin
                    for (int v = 0; v < n; v++) begin
                        acc_j = 0;
                        acc_u = 0;
                        acc_d = 0;
                        for (int l = 0; l < n; l++) begin
                            for (int s = 0; s < n; s++) begin
                                kk = l * MaxBasis + s;
                                pt = eri[((m*MaxBasis + v)*MaxBasis + l)*MaxBasis + s];
                                acc_j += q16_round(ptot[kk] * pt);
                                pt = eri[((m*MaxBasis + l)*MaxBasis + s)*MaxBasis + v];
                                acc_u += q16_round(longint'(dens_up[kk]) * pt);
                                acc_d += q16_round(longint'(dens_dn[kk]) * pt);
                            end
                        end
                        pt     = core_m[m * MaxBasis + v];
                        e.row  = m[2:0];
                        e.col  = v[2:0];
                        e.up   = q16_clip(pt + acc_j - acc_u);
                        e.dn   = q16_clip(pt + acc_j - acc_d);
                        e.last = (m == n - 1) && (v == n - 1);
                        fock_q.push_back(e);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    task automatic send_item(input logic [2:0] op, input logic [2:0] r, c, t, f,
                             input int val);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.operation    <= op;
        in_ch.row_index    <= r;
        in_ch.col_index    <= c;
        in_ch.third_index  <= t;
        in_ch.fourth_index <= f;
        in_ch.value        <= val;
        in_ch.valid        <= 1'b1;
        do @(negedge i_clk); while (!in_ch.ready);
        @(posedge i_clk);
        fock_predict(op, r, c, t, f, val);
        items_sent++;
    endtask

    // register write, only once the block has gone quiet
    task automatic write_reg(input t_cfg_idx idx, input logic [16:0] data);
        in_ch.valid <= 1'b0;
        while (fock_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_BASIS:    n_basis  = data[3:0];
            CFG_OCC_UP:   n_occ_up = data[3:0];
            CFG_OCC_DOWN: n_occ_dn = data[3:0];
            CFG_WEIGHT:   mix_w    = data;
            default: ;
        endcase
    endtask

    function automatic int rand_val();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return int'($urandom_range(0, 262143)) - 131072;
            2: case ($urandom_range(0, 3))
                   0: return 32'sh7fff_ffff;
                   1: return 32'sh8000_0000;
                   2: return 32'sh0001_0000;
                   default: return 32'sh0000_0000;
               endcase
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // stray transaction: spare opcode or a load anywhere
    task automatic send_noise();
        if ($urandom_range(0, 1) == 0)
            send_item(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), 3'($urandom),
                      3'($urandom), 3'($urandom), 3'($urandom), int'($urandom));
        else
            send_item(3'($urandom_range(OP_LOAD_UP, OP_LOAD_INT)), 3'($urandom),
                      3'($urandom), 3'($urandom), 3'($urandom), rand_val());
    endtask

    // load every entry a run of size n reads, refreshing some on small sizes
    task automatic fill_block(input int n);
        bit redo;
        int kk;
        for (int a = 0; a < n; a++) begin
            for (int b = 0; b < n; b++) begin
                kk   = a * MaxBasis + b;
                redo = (n <= 4) && ($urandom_range(0, 3) == 0);
                if (!wr_core[kk] || redo)
                    send_item(OP_LOAD_CORE, 3'(a), 3'(b), 3'($urandom), 3'($urandom),
                              rand_val());
                if (!wr_up[kk] || redo)
                    send_item(OP_LOAD_UP, 3'(a), 3'(b), 3'($urandom), 3'($urandom),
                              rand_val());
                if (!wr_dn[kk] || redo)
                    send_item(OP_LOAD_DOWN, 3'(a), 3'(b), 3'($urandom), 3'($urandom),
                              rand_val());
                if (n <= 4 && $urandom_range(0, 9) == 0)
                    send_noise();
                for (int c = 0; c < n; c++) begin
                    for (int d = 0; d < n; d++) begin
                        if (!wr_eri[kk * SQ + c * MaxBasis + d] || redo)
                            send_item(OP_LOAD_INT, 3'(a), 3'(b), 3'(c), 3'(d), rand_val());
                    end
                end
            end
        end
    endtask

    task automatic add_reg(input t_cfg_idx idx, input logic [16:0] data);
        dir_q.push_back('{1'b1, idx, data, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 0, 1'b0, 0});
    endtask

    task automatic add_item(input logic [2:0] op, input logic [2:0] r, c, t, f, input int val,
                            input bit typed, input int exp_fock);
        dir_q.push_back('{1'b0, CFG_BASIS, 17'd0, op, r, c, t, f, val, typed, exp_fock});
    endtask

    // ------------------------------------------------------------------
    // Output side: ready with random stalls and one long hold
    // ------------------------------------------------------------------
    initial begin
        int gap_cnt;
        int hold_cnt;
        bit held;
        gap_cnt  = 0;
        hold_cnt = 0;
        held     = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !held) begin
                held     = 1;
                hold_cnt = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_ch.ready <= 1'b0;
            end else if (gap_cnt > 0) begin
                gap_cnt--;
                out_ch.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                gap_cnt = $urandom_range(0, 4);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // result checker
    always @(negedge i_clk) begin
        fock_entry_t e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (fock_q.size() == 0) begin
                errs++;
                if (errs <= 10)
                    $display("unexpected result row %0d col %0d up %h down %h last %b",
                             out_ch.out_row, out_ch.out_col, out_ch.fock_up,
                             out_ch.fock_down, out_ch.last);
            end else begin
                e = fock_q.pop_front();
                if (out_ch.out_row !== e.row || out_ch.out_col !== e.col ||
                    out_ch.fock_up !== e.up || out_ch.fock_down !== e.dn ||
                    out_ch.last !== e.last) begin
                    errs++;
                    if (errs <= 10)
                        $display("mismatch exp r%0d c%0d up %h dn %h l%b / got r%0d c%0d up %h dn %h l%b",
                                 e.row, e.col, e.up, e.dn, e.last,
                                 out_ch.out_row, out_ch.out_col, out_ch.fock_up,
                                 out_ch.fock_down, out_ch.last);
                end
            end
        end
    end

    // watchdog: cycles with no transaction on either channel
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_cnt = 0;
            else
                stall_cnt++;
            if (stall_cnt >= CYCLE_LIMIT) begin
                $display("[hartree_fock_fock_build] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        stim_row_t   row;
        fock_entry_t e;
        int          n, runs;
        logic [16:0] wsel;

        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = CFG_BASIS;
        i_cfg_data         = '0;
        in_ch.valid        = 1'b0;
        in_ch.operation    = OP_LOAD_UP;
        in_ch.row_index    = '0;
        in_ch.col_index    = '0;
        in_ch.third_index  = '0;
        in_ch.fourth_index = '0;
        in_ch.value        = '0;
        foreach (coef_up[i]) begin
            coef_up[i] = 0; coef_dn[i] = 0; core_m[i] = 0;
            dens_up[i] = 0; dens_dn[i] = 0;
            wr_up[i] = 0; wr_dn[i] = 0; wr_core[i] = 0;
        end
        foreach (eri[i]) begin
            eri[i]    = 0;
            wr_eri[i] = 0;
        end

        // directed: single basis function, extremes of core and weight
        add_reg(CFG_BASIS, 17'd1);
        add_item(OP_LOAD_CORE, 0, 0, 0, 0, 32'sh7fff_ffff, 0, 0);
        add_item(OP_LOAD_INT,  0, 0, 0, 0, 32'sh8000_0000, 0, 0);
        add_item(OP_LOAD_UP,   0, 0, 0, 0, 32'sh0001_0000, 0, 0);
        add_item(OP_LOAD_DOWN, 0, 0, 0, 0, 32'shffff_0000, 0, 0);
        // no occupied orbitals and zero densities: Fock equals core
        add_item(OP_RUN, 0, 0, 0, 0, 0, 1, 32'sh7fff_ffff);
        add_reg(CFG_OCC_UP, 17'd15);
        add_reg(CFG_OCC_DOWN, 17'd1);
        add_item(OP_RUN, 7, 7, 7, 7, -1, 0, 0);
        add_reg(CFG_WEIGHT, 17'd0);
        add_item(OP_RUN, 0, 0, 0, 0, 0, 0, 0);
        add_reg(CFG_WEIGHT, 17'h1ffff);
        add_item(OP_LOAD_CORE, 0, 0, 0, 0, 32'sh8000_0000, 0, 0);
        add_item(OP_LOAD_INT,  0, 0, 0, 0, 0, 0, 0);
        // zero integrals: Fock equals core
        add_item(OP_RUN, 0, 0, 0, 0, 0, 1, 32'sh8000_0000);
        add_item(OP_SPARE_FIRST, 7, 7, 7, 7, -1, 0, 0);
        add_item(3'(OP_SPARE_FIRST + 3'd1), 0, 0, 0, 0, 32'sh7fff_ffff, 0, 0);
        add_item(OP_SPARE_LAST, 7, 0, 7, 0, -1, 0, 0);
        add_item(OP_RUN, 0, 0, 0, 0, 0, 1, 32'sh8000_0000);
        // zero basis functions: run is a no-op
        add_reg(CFG_BASIS, 17'd0);
        add_item(OP_RUN, 0, 0, 0, 0, 0, 0, 0);
        add_reg(CFG_WEIGHT, 17'd32768);
        add_reg(CFG_BASIS, 17'd1);
        add_item(OP_LOAD_INT, 0, 0, 0, 0, 32'sh7fff_ffff, 0, 0);
        add_item(OP_RUN, 0, 0, 0, 0, 0, 0, 0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_q[i]) begin
            row = dir_q[i];
            if (row.is_reg) begin
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                send_item(row.op, row.r, row.c, row.t, row.f, row.val);
                if (row.typed) begin
                    e    = fock_q.pop_back();
                    e.up = row.exp_fock;
                    e.dn = row.exp_fock;
                    fock_q.push_back(e);
                end
            end
        end

        // random phases: configure, fill the small block in use, run
        for (int p = 0; p < PHASES || items_sent < ITEM_TARGET; p++) begin
            quiet = (p >= PHASES - 3);
            if (p % 3 == 0)
                n = 2;
            else
                n = $urandom_range(1, 2);
            case ($urandom_range(0, 3))
                0: wsel = 17'd0;
                1: wsel = WeightOne;
                2: wsel = 17'($urandom_range(WeightOne + 1, 17'h1ffff));
                default: wsel = 17'($urandom_range(0, WeightOne));
            endcase
            write_reg(CFG_BASIS, 17'(n));
            write_reg(CFG_OCC_UP, 17'($urandom_range(0, 15)));
            write_reg(CFG_OCC_DOWN, 17'($urandom_range(0, 15)));
            write_reg(CFG_WEIGHT, wsel);
            fill_block(n);
            if (p == 2)
                hold_req = 1;
            runs = (p == 2) ? 2 : $urandom_range(1, 2);
            repeat (runs)
                send_item(OP_RUN, 3'($urandom), 3'($urandom), 3'($urandom), 3'($urandom),
                          int'($urandom));
            if (p == 2)
                repeat (6) send_noise();
        end

        in_ch.valid <= 1'b0;
        while (fock_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errs == 0 && fock_q.size() == 0)
            $display("[hartree_fock_fock_build] OK");
        else
            $display("[hartree_fock_fock_build] ERROR");
        $finish;
    end

endmodule
